/* rtl/nlm_pkg.sv */
// nlm_pkg: shared constants and types of the N-dimensional nearest-entry LUT mapper.
// No dependencies; imported by the controller, the datapath and the top level.

package nlm_pkg;

   // Fixed field geometry
   localparam int COORD_FIELDS = 4;
   localparam int DIM_W        = 2;
   localparam int COORD_W      = 8;
   localparam int SIZE_W       = 9;
   localparam int DIMS_W       = 3;
   localparam int BPE_W        = 5;
   localparam int LOAD_ADDR_W  = 16;
   localparam int BYTE_W       = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 9;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_DIMS_IN_USE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_DIM0       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_DIM1       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_DIM2       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_DIM3       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_ENTRY = 3'd5;

   // Item command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic load_we;   // write one table byte
      logic start;     // latch a lookup item, clear accumulators
      logic kmul;      // index of current dimension
      logic pmul;      // index times weight, next weight
      logic acc;       // accumulate address, advance dimension
      logic check;     // end-of-memory check, set read pointer
      logic rd_en;     // read and present one entry byte
   } nlm_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic bpe_zero;
      logic last_dim;
      logic byte_last;
      logic out_free;
   } nlm_status_type;

endpackage

/* rtl/nd_nearest_lut_mapper.sv */
// nd_nearest_lut_mapper: top level, N-dimensional nearest-entry lookup table mapper.
// Depends on nlm_pkg, nlm_ctrl and nlm_datapath.
// Load item: ready stays high, so loads run one per cycle while no lookup is in progress.
// Lookup over n dimensions: a KMUL, PMUL and ACC step per dimension plus an end-of-memory check;
//   then one byte per cycle while the result register is free; next item after the last byte is read.
// Reset (synchronous): controller idle, defaults restored; table undefined until loaded.

module nd_nearest_lut_mapper #(
   parameter int MAX_DIMS        = 4,
   parameter int TABLE_BYTES     = 65536,
   parameter int MAX_ENTRY_BYTES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration write port
   input  logic                            csr_write_enable,
   input  logic [nlm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nlm_pkg::CSR_DATA_W-1:0]  csr_write_data,
   // input items
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [nlm_pkg::LOAD_ADDR_W-1:0] req_load_address,
   input  logic [nlm_pkg::BYTE_W-1:0]      req_load_byte,
   input  logic [nlm_pkg::COORD_W-1:0]     req_coord_0,
   input  logic [nlm_pkg::COORD_W-1:0]     req_coord_1,
   input  logic [nlm_pkg::COORD_W-1:0]     req_coord_2,
   input  logic [nlm_pkg::COORD_W-1:0]     req_coord_3,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [nlm_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_last,
   output logic                            rsp_out_of_range
);
   import nlm_pkg::*;

   nlm_cmd_type    cmd;
   nlm_status_type status;

   // Sequencer: accepts items only when idle; the last byte may still sit in the
   // result register while the next item is taken.
   nlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: config, address math with sticky overflow flags, table memory, result register.
   nlm_datapath #(
      .MAX_DIMS        (MAX_DIMS),
      .TABLE_BYTES     (TABLE_BYTES),
      .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_load_address (req_load_address),
      .req_load_byte    (req_load_byte),
      .req_coord_0      (req_coord_0),
      .req_coord_1      (req_coord_1),
      .req_coord_2      (req_coord_2),
      .req_coord_3      (req_coord_3),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // A load never holds off the next item.
   a_load_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == CMD_LOAD)) |=> req_ready)
      else $error("load item dropped ready");

   // A lookup with a nonzero entry width occupies the sequencer.
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == CMD_LOOKUP) && !status.bpe_zero) |=> !req_ready)
      else $error("lookup item did not start the sequencer");

   // Out-of-range bytes read as zero.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_out_byte == '0))
      else $error("out-of-range item carries a nonzero byte");

   // A new byte is only read when the result register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en) |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten before it was taken");

endmodule

/* rtl/nlm_ctrl.sv */
// nlm_ctrl: sequencer of the LUT mapper (load, per-dimension address steps, byte emit).
// Depends on nlm_pkg for command and status structs.

module nlm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_ready,
   input  nlm_pkg::nlm_status_type status,
   output nlm_pkg::nlm_cmd_type    cmd
);
   import nlm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_KMUL  = 6'b000010,
      ST_PMUL  = 6'b000100,
      ST_ACC   = 6'b001000,
      ST_CHECK = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_LOOKUP) begin
                  cmd.start = 1'b1;
                  // zero-width entry: item consumed, nothing emitted
                  if (!status.bpe_zero) state_in = ST_KMUL;
               end else begin
                  cmd.load_we = 1'b1;
               end
            end
         end
         ST_KMUL: begin
            cmd.kmul = 1'b1;
            state_in = ST_PMUL;
         end
         ST_PMUL: begin
            cmd.pmul = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.last_dim ? ST_CHECK : ST_KMUL;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.rd_en = 1'b1;
               if (status.byte_last) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/nlm_datapath.sv */
// nlm_datapath: config registers, address arithmetic, table memory and result register.
// Depends on nlm_pkg; driven by nlm_ctrl through nlm_cmd_type.

module nlm_datapath #(
   parameter int MAX_DIMS        = 4,
   parameter int TABLE_BYTES     = 65536,
   parameter int MAX_ENTRY_BYTES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [nlm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nlm_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic [nlm_pkg::LOAD_ADDR_W-1:0]    req_load_address,
   input  logic [nlm_pkg::BYTE_W-1:0]         req_load_byte,
   input  logic [nlm_pkg::COORD_W-1:0]        req_coord_0,
   input  logic [nlm_pkg::COORD_W-1:0]        req_coord_1,
   input  logic [nlm_pkg::COORD_W-1:0]        req_coord_2,
   input  logic [nlm_pkg::COORD_W-1:0]        req_coord_3,
   input  nlm_pkg::nlm_cmd_type               cmd,
   output nlm_pkg::nlm_status_type            status,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [nlm_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                               rsp_last,
   output logic                               rsp_out_of_range
);
   import nlm_pkg::*;

   localparam int AW      = $clog2(TABLE_BYTES);
   localparam int VW      = $clog2(TABLE_BYTES + 1) + 1;  // holds at least twice the table size
   localparam int PW      = VW + SIZE_W;
   localparam int EW      = $clog2(MAX_ENTRY_BYTES + 1);
   localparam int CK_W    = COORD_W + SIZE_W;
   localparam int DIM_LIM = (MAX_DIMS < COORD_FIELDS) ? MAX_DIMS : COORD_FIELDS;
   localparam logic [PW-1:0] LIM = PW'(TABLE_BYTES);

   // configuration
   logic [DIMS_W-1:0]  dims_ff;
   logic [SIZE_W-1:0]  size_ff [COORD_FIELDS];
   logic [BPE_W-1:0]   bpe_ff;

   // lookup state
   logic [COORD_W-1:0] coord_ff [COORD_FIELDS];
   logic [DIM_W-1:0]   d_ff;
   logic [SIZE_W-1:0]  k_ff;
   logic [VW-1:0]      off_ff, prod_ff, addr_ff;
   logic               off_big_ff, prod_big_ff, addr_big_ff;
   logic               oor_ff;
   logic [AW-1:0]      rd_ptr_ff;
   logic [EW-1:0]      b_ff;

   // table and result
   logic [BYTE_W-1:0]  table_mem_ff [TABLE_BYTES];
   logic [BYTE_W-1:0]  mem_q_ff;
   logic               rsp_valid_ff, last_q_ff, oor_q_ff;

   logic [DIMS_W-1:0]  n_eff;
   logic [EW-1:0]      bpe_sat;
   logic [COORD_W-1:0] coord_sel;
   logic [SIZE_W-1:0]  size_sel;
   logic [CK_W-1:0]    ck_prod;
   logic [PW-1:0]      prod_full, off_full, acc_sum, end_sum;
   logic               load_in_range;

   always_comb begin
      n_eff = dims_ff;
      if (n_eff == '0) n_eff = DIMS_W'(1);
      if (n_eff > DIMS_W'(DIM_LIM)) n_eff = DIMS_W'(DIM_LIM);
   end

   assign bpe_sat = (int'(bpe_ff) > MAX_ENTRY_BYTES) ? EW'(MAX_ENTRY_BYTES) : EW'(bpe_ff);

   assign coord_sel = coord_ff[d_ff];
   assign size_sel  = size_ff[d_ff];
   assign ck_prod   = CK_W'(coord_sel) * CK_W'(size_sel);
   assign prod_full = PW'(off_ff) * PW'(k_ff);
   assign off_full  = PW'(off_ff) * PW'(size_sel);
   assign acc_sum   = PW'(addr_ff) + PW'(prod_ff);
   assign end_sum   = PW'(addr_ff) + PW'(bpe_sat);

   assign load_in_range = (32'(req_load_address) < 32'(TABLE_BYTES));

   assign status.bpe_zero  = (bpe_ff == '0);
   assign status.last_dim  = ({1'b0, d_ff} == (n_eff - DIMS_W'(1)));
   assign status.byte_last = (b_ff == (bpe_sat - EW'(1)));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = oor_q_ff ? '0 : mem_q_ff;
   assign rsp_last         = last_q_ff;
   assign rsp_out_of_range = oor_q_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_W'(1);
         for (int i = 0; i < COORD_FIELDS; i++) size_ff[i] <= SIZE_W'(1);
         bpe_ff  <= BPE_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DIMS_IN_USE:     dims_ff    <= csr_write_data[DIMS_W-1:0];
            CSR_SIZE_DIM0:       size_ff[0] <= csr_write_data[SIZE_W-1:0];
            CSR_SIZE_DIM1:       size_ff[1] <= csr_write_data[SIZE_W-1:0];
            CSR_SIZE_DIM2:       size_ff[2] <= csr_write_data[SIZE_W-1:0];
            CSR_SIZE_DIM3:       size_ff[3] <= csr_write_data[SIZE_W-1:0];
            CSR_BYTES_PER_ENTRY: bpe_ff     <= csr_write_data[BPE_W-1:0];
            default: ;
         endcase
      end
   end

   // address arithmetic; values above the table size only keep a sticky flag
   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else begin
         if (cmd.start) begin
            coord_ff[0] <= req_coord_0;
            coord_ff[1] <= req_coord_1;
            coord_ff[2] <= req_coord_2;
            coord_ff[3] <= req_coord_3;
            d_ff        <= '0;
            addr_ff     <= '0;
            addr_big_ff <= 1'b0;
            off_ff      <= VW'(bpe_sat);
            off_big_ff  <= 1'b0;
         end
         if (cmd.kmul) begin
            k_ff <= ck_prod[CK_W-1:COORD_W];
         end
         if (cmd.pmul) begin
            prod_ff     <= prod_full[VW-1:0];
            prod_big_ff <= (off_big_ff && (k_ff != '0)) || (prod_full > LIM);
            off_ff      <= off_full[VW-1:0];
            off_big_ff  <= (off_big_ff && (size_sel != '0)) || (off_full > LIM);
         end
         if (cmd.acc) begin
            addr_ff     <= acc_sum[VW-1:0];
            addr_big_ff <= addr_big_ff || prod_big_ff || (acc_sum > LIM);
            d_ff        <= d_ff + DIM_W'(1);
         end
         if (cmd.check) begin
            oor_ff    <= addr_big_ff || (end_sum > LIM);
            rd_ptr_ff <= addr_ff[AW-1:0];
            b_ff      <= '0;
         end
         if (cmd.rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
            b_ff      <= b_ff + EW'(1);
         end
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_we && load_in_range) begin
         table_mem_ff[AW'(req_load_address)] <= req_load_byte;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= table_mem_ff[rd_ptr_ff];
      end
   end

   // result register: the read data register holds while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            rsp_valid_ff <= 1'b1;
            last_q_ff    <= status.byte_last;
            oor_q_ff     <= oor_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
